// File: hdl/fin_angle_from_force_top_defines.svh
// ----------------------------------------------------------------------------
// fin_angle_from_force_top_defines.svh
// Assertion helpers used by the fin angle back end.
// ----------------------------------------------------------------------------
`ifndef FIN_ANGLE_FROM_FORCE_TOP_DEFINES_SVH
`define FIN_ANGLE_FROM_FORCE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define FAF_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define FAF_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/faf_pkg.sv
// ----------------------------------------------------------------------------
// faf_pkg
// Types and fixed widths of the fin angle from force block.
// ----------------------------------------------------------------------------
package faf_pkg;

  // Register file indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIFT_A     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIFT_B     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIFT_C     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ANGLE  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PROP_CONST = 3'd4;

  // Shifted curve constant c - coefficient, sized for the widest word
  localparam int CP_BITS   = 49;
  localparam int CPM_BITS  = 48;
  // |a| * |c'| and the discriminant
  localparam int PROD_BITS = 80;
  localparam int DISC_BITS = 82;
  localparam int SQRT_BITS = 41;
  // Root numerators -b +/- s
  localparam int NUM_BITS  = 43;
  // Root divider: dividend, divisor and quotient widths
  localparam int RDIV_N    = 64;
  localparam int RDIV_D    = 33;
  localparam int RDIV_Q    = 24;
  localparam int ANGLE_BITS = 23;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIN  = 2'd1,
    KIND_QUAD = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [31:0] lift_coeff_a;
    logic signed [31:0] lift_coeff_b;
    logic signed [31:0] lift_coeff_c;
    logic [ANGLE_BITS-1:0] max_angle;
    logic [30:0] prop_constant;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] force_req;
    logic [30:0] rotor_rate;
  } item_t;

  typedef struct packed {
    logic signed [23:0] fin_angle;
    logic [1:0] root_count;
    logic clamped;
  } result_t;

  typedef struct packed {
    kind_t kind;
    logic signed [CP_BITS-1:0] cp;
    logic force_pos;
    logic clamped;
  } job_t;

endpackage

// File: hdl/faf_divider.sv
// ----------------------------------------------------------------------------
// faf_divider
// Restoring divider, one quotient bit a cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module faf_divider #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient,
  output logic          ovf
);

  localparam int HW   = NW - QW;
  localparam int CW   = (HW > DW) ? HW : DW;
  localparam int CNTW = $clog2(QW + 1);

  logic [CW-1:0]   hi_x;
  logic [CW-1:0]   dv_x;
  logic            too_big;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [QW-1:0]   low;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  // Quotient overflows when the upper dividend part already reaches the divisor
  assign hi_x    = CW'(dividend[NW-1:QW]);
  assign dv_x    = CW'(divisor);
  assign too_big = hi_x >= dv_x;

  // One restoring step
  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= !too_big;
      cnt  <= CNTW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr      <= divisor;
      rem      <= hi_x[DW-1:0];
      low      <= dividend[QW-1:0];
      quotient <= '0;
      ovf      <= too_big;
    end else if (busy) begin
      rem      <= fits ? diff[DW-1:0] : trial[DW-1:0];
      low      <= low << 1;
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

// File: hdl/faf_front.sv
// ----------------------------------------------------------------------------
// faf_front
// Takes request words, finds the lift coefficient and classifies the curve.
// ----------------------------------------------------------------------------
module faf_front #(
  parameter int WORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  faf_pkg::cfg_t   cfg,
  input  logic            push,
  output logic            full,
  input  faf_pkg::item_t  item,
  input  logic            q_full,
  output logic            q_push,
  output faf_pkg::job_t   job
);

  localparam int QW = WORD_BITS - 1;
  localparam logic [QW-1:0] COEF_MAX = {QW{1'b1}};

  logic               hold_v;
  faf_pkg::item_t     hold;
  logic               mul_v;
  logic [62:0]        num;
  logic [61:0]        den;
  logic               mul_fpos;
  logic               div_v;
  logic               div_fpos;
  logic               div_start;
  logic               div_busy;
  logic [QW-1:0]      div_q;
  logic               div_ovf;
  logic [31:0]        f_u;
  logic [31:0]        mag;
  logic [QW-1:0]      coef;
  logic signed [faf_pkg::CP_BITS-1:0] c_x;
  logic signed [faf_pkg::CP_BITS-1:0] coef_x;

  assign full = hold_v;

  // Magnitude of the demanded force
  assign f_u = hold.force_req;
  assign mag = hold.force_req[31] ? (~f_u + 32'd1) : f_u;

  // Advance the stages
  assign q_push    = div_v && !div_busy && !q_full;
  assign div_start = mul_v && (!div_v || q_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      mul_v  <= 1'b0;
      div_v  <= 1'b0;
    end else begin
      if (push && !hold_v) begin
        hold_v <= 1'b1;
      end else if (hold_v && (!mul_v || div_start)) begin
        hold_v <= 1'b0;
      end
      if (hold_v && (!mul_v || div_start)) begin
        mul_v <= 1'b1;
      end else if (div_start) begin
        mul_v <= 1'b0;
      end
      if (div_start) begin
        div_v <= 1'b1;
      end else if (q_push) begin
        div_v <= 1'b0;
      end
    end
  end

  // Hold the word, then form numerator and speed squared
  always_ff @(posedge clk) begin
    if (push && !hold_v) begin
      hold <= item;
    end
    if (hold_v && (!mul_v || div_start)) begin
      num      <= 63'(mag) * 63'(cfg.prop_constant);
      den      <= 62'(hold.rotor_rate) * 62'(hold.rotor_rate);
      mul_fpos <= !hold.force_req[31] && (hold.force_req != 32'sd0);
    end
    if (div_start) begin
      div_fpos <= mul_fpos;
    end
  end

  // Coefficient = num * 2^16 / den, saturated to the word limit
  faf_divider #(
    .NW(79),
    .DW(62),
    .QW(QW)
  ) u_coef_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num, 16'd0}),
    .divisor  (den),
    .busy     (div_busy),
    .quotient (div_q),
    .ovf      (div_ovf)
  );

  // Shift the curve constant and classify
  assign coef   = div_ovf ? COEF_MAX : div_q;
  assign c_x    = {{(faf_pkg::CP_BITS-32){cfg.lift_coeff_c[31]}}, cfg.lift_coeff_c};
  assign coef_x = {{(faf_pkg::CP_BITS-QW){1'b0}}, coef};

  always_comb begin
    job.cp        = c_x - coef_x;
    job.force_pos = div_fpos;
    job.clamped   = div_ovf;
    if (cfg.lift_coeff_a != 32'sd0) begin
      job.kind = faf_pkg::KIND_QUAD;
    end else if (cfg.lift_coeff_b != 32'sd0) begin
      job.kind = faf_pkg::KIND_LIN;
    end else begin
      job.kind = faf_pkg::KIND_NONE;
    end
  end

endmodule

// File: hdl/faf_queue.sv
// ----------------------------------------------------------------------------
// faf_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module faf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  faf_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output faf_pkg::job_t dout,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  faf_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;
  logic          wr;
  logic          rd;

  assign full  = cnt == (PW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= din;
    end
  end

endmodule

// File: hdl/faf_back.sv
// ----------------------------------------------------------------------------
// faf_back
// Solves the lift curve for the angle and holds the result word.
// ----------------------------------------------------------------------------
`include "fin_angle_from_force_top_defines.svh"

module faf_back (
  input  logic             clk,
  input  logic             rst,
  input  faf_pkg::cfg_t    cfg,
  input  logic             q_empty,
  output logic             q_pop,
  input  faf_pkg::job_t    job,
  output logic             empty,
  input  logic             pop,
  output faf_pkg::result_t result
);

  localparam int CPW   = faf_pkg::CP_BITS;
  localparam int CPM   = faf_pkg::CPM_BITS;
  localparam int PRW   = faf_pkg::PROD_BITS;
  localparam int DSW   = faf_pkg::DISC_BITS;
  localparam int SQW   = faf_pkg::SQRT_BITS;
  localparam int NMW   = faf_pkg::NUM_BITS;
  localparam int RQW   = faf_pkg::RDIV_Q;
  localparam int AW    = faf_pkg::ANGLE_BITS;
  localparam int MUL_STEPS = CPM / 16;
  localparam int SCW   = $clog2(SQW + 1);
  localparam logic [DSW-1:0] ONE_TOP = DSW'(1) << (2 * SQW - 2);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_DISC = 6'b000100,
    B_SQRT = 6'b001000,
    B_DIV  = 6'b010000,
    B_DONE = 6'b100000
  } bstate_t;

  bstate_t              state;
  faf_pkg::kind_t       kind;
  logic                 fpos;
  logic                 jclamp;
  logic                 none;
  logic                 cp_neg;
  logic                 cp_nz;
  logic [CPM-1:0]       cps;
  logic [31:0]          am;
  logic [63:0]          bb;
  logic [47:0]          pp;
  logic [PRW-1:0]       acc;
  logic [1:0]           mcnt;
  logic [DSW-1:0]       op;
  logic [DSW-1:0]       res;
  logic [DSW-1:0]       one;
  logic [SCW-1:0]       scnt;
  logic                 neg0;
  logic                 neg1;
  logic                 out_v;
  logic                 load;

  logic                 a_neg;
  logic [31:0]          a_mag;
  logic [31:0]          b_mag;
  logic                 b_pos;
  logic                 j_neg;
  logic [CPW-1:0]       j_mag_full;
  logic [CPM-1:0]       j_mag;
  logic                 j_pos;
  logic [DSW:0]         dsum;
  logic [DSW-1:0]       trial;
  logic                 ge;
  logic [SQW-1:0]       s;
  logic signed [NMW-1:0] b_x;
  logic signed [NMW-1:0] s_x;
  logic signed [NMW-1:0] n0;
  logic signed [NMW-1:0] n1;
  logic [NMW-1:0]       n0m;
  logic [NMW-1:0]       n1m;
  logic                 sqrt_end;
  logic                 lin_go;
  logic                 d0_start;
  logic [faf_pkg::RDIV_N-1:0] d0_n;
  logic [faf_pkg::RDIV_D-1:0] d0_d;
  logic                 busy0;
  logic                 busy1;
  logic [RQW-1:0]       q0;
  logic [RQW-1:0]       q1;
  logic                 ovf0;
  logic                 ovf1;

  logic [AW-1:0]        lim;
  logic                 zero0;
  logic                 zero1;
  logic                 big0;
  logic                 big1;
  logic                 r0neg;
  logic                 r1neg;
  logic                 in0;
  logic                 in1;
  logic [AW-1:0]        ang;
  logic [1:0]           rcnt;
  logic                 cl;
  logic [23:0]          ang_x;

  // Magnitudes of the curve terms and of the incoming constant
  assign a_neg      = cfg.lift_coeff_a[31];
  assign a_mag      = a_neg ? (~cfg.lift_coeff_a + 32'd1) : cfg.lift_coeff_a;
  assign b_mag      = cfg.lift_coeff_b[31] ? (~cfg.lift_coeff_b + 32'd1) : cfg.lift_coeff_b;
  assign b_pos      = !cfg.lift_coeff_b[31] && (cfg.lift_coeff_b != 32'sd0);
  assign j_neg      = job.cp[CPW-1];
  assign j_mag_full = j_neg ? (~job.cp + 1'b1) : job.cp;
  assign j_mag      = j_mag_full[CPM-1:0];
  assign j_pos      = !j_neg && (job.cp != '0);

  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign lin_go = q_pop && (job.kind == faf_pkg::KIND_LIN);

  // Discriminant b^2 - 4a(c - coef) from magnitudes and signs
  always_comb begin
    if ((cp_neg == a_neg) && cp_nz) begin
      dsum = (DSW+1)'(bb) - {1'b0, acc, 2'b00};
    end else begin
      dsum = (DSW+1)'(bb) + {1'b0, acc, 2'b00};
    end
  end

  // One square root digit
  assign trial = res + one;
  assign ge    = op >= trial;

  // Root numerators -b + s and -b - s
  assign s        = res[SQW-1:0];
  assign b_x      = {{(NMW-32){cfg.lift_coeff_b[31]}}, cfg.lift_coeff_b};
  assign s_x      = {{(NMW-SQW){1'b0}}, s};
  assign n0       = s_x - b_x;
  assign n1       = -b_x - s_x;
  assign n0m      = n0[NMW-1] ? (~n0 + 1'b1) : n0;
  assign n1m      = n1[NMW-1] ? (~n1 + 1'b1) : n1;
  assign sqrt_end = (state == B_SQRT) && (scnt == '0);

  // Divider 0 serves the linear root or the first quadratic root
  assign d0_start = lin_go || sqrt_end;
  assign d0_n     = sqrt_end ? faf_pkg::RDIV_N'({n0m, 16'd0})
                             : faf_pkg::RDIV_N'({j_mag, 16'd0});
  assign d0_d     = sqrt_end ? {a_mag, 1'b0} : {1'b0, b_mag};

  faf_divider #(
    .NW(faf_pkg::RDIV_N),
    .DW(faf_pkg::RDIV_D),
    .QW(RQW)
  ) u_root0_div (
    .clk      (clk),
    .rst      (rst),
    .start    (d0_start),
    .dividend (d0_n),
    .divisor  (d0_d),
    .busy     (busy0),
    .quotient (q0),
    .ovf      (ovf0)
  );

  faf_divider #(
    .NW(faf_pkg::RDIV_N),
    .DW(faf_pkg::RDIV_D),
    .QW(RQW)
  ) u_root1_div (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_end),
    .dividend (faf_pkg::RDIV_N'({n1m, 16'd0})),
    .divisor  ({a_mag, 1'b0}),
    .busy     (busy1),
    .quotient (q1),
    .ovf      (ovf1)
  );

  // Sequence one word through the solver
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_v <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            case (job.kind)
              faf_pkg::KIND_LIN:  state <= B_DIV;
              faf_pkg::KIND_QUAD: state <= B_MUL;
              default:            state <= B_DONE;
            endcase
          end
        end
        B_MUL: begin
          if (mcnt == 2'(MUL_STEPS)) begin
            state <= B_DISC;
          end
        end
        B_DISC: begin
          state <= dsum[DSW] ? B_DONE : B_SQRT;
        end
        B_SQRT: begin
          if (sqrt_end) begin
            state <= B_DIV;
          end
        end
        B_DIV: begin
          if (!busy0 && !busy1) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (load) begin
        out_v <= 1'b1;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_pop) begin
          kind   <= job.kind;
          fpos   <= job.force_pos;
          jclamp <= job.clamped;
          cp_neg <= j_neg;
          cp_nz  <= job.cp != '0;
          cps    <= j_mag;
          am     <= a_mag;
          bb     <= 64'(b_mag) * 64'(b_mag);
          acc    <= '0;
          mcnt   <= '0;
          none   <= 1'b0;
          neg0   <= (j_pos == b_pos);
        end
      end
      B_MUL: begin
        if (mcnt != 2'(MUL_STEPS)) begin
          pp  <= 48'(am) * 48'(cps[CPM-1 -: 16]);
          cps <= cps << 16;
        end
        if (mcnt != 2'd0) begin
          acc <= (acc << 16) + PRW'(pp);
        end
        mcnt <= mcnt + 2'd1;
      end
      B_DISC: begin
        none <= dsum[DSW];
        op   <= dsum[DSW-1:0];
        res  <= '0;
        one  <= ONE_TOP;
        scnt <= SCW'(SQW);
      end
      B_SQRT: begin
        if (scnt != '0) begin
          op   <= ge ? (op - trial) : op;
          res  <= ge ? ((res >> 1) + one) : (res >> 1);
          one  <= one >> 2;
          scnt <= scnt - 1'b1;
        end else begin
          neg0 <= n0[NMW-1] != a_neg;
          neg1 <= n1[NMW-1] != a_neg;
        end
      end
      default: begin
      end
    endcase
  end

  // Pick the root and limit it
  assign lim   = cfg.max_angle;
  assign zero0 = !ovf0 && (q0 == '0);
  assign zero1 = !ovf1 && (q1 == '0);
  assign big0  = ovf0 || (q0 > RQW'(lim));
  assign big1  = ovf1 || (q1 > RQW'(lim));
  assign r0neg = neg0 && !zero0;
  assign r1neg = neg1 && !zero1;
  assign in0   = !r0neg && !big0;
  assign in1   = !r1neg && !big1;

  always_comb begin
    ang  = lim;
    rcnt = 2'd0;
    cl   = 1'b1;
    case (kind)
      faf_pkg::KIND_LIN: begin
        rcnt = 2'd1;
        if (zero0) begin
          ang = '0;
          cl  = 1'b0;
        end else if (neg0) begin
          ang = '0;
        end else if (!big0) begin
          ang = q0[AW-1:0];
          cl  = 1'b0;
        end
      end
      faf_pkg::KIND_QUAD: begin
        if (!none) begin
          if (s == '0) begin
            rcnt = 2'd1;
            if (r0neg) begin
              ang = '0;
            end else if (!big0) begin
              ang = q0[AW-1:0];
              cl  = 1'b0;
            end
          end else begin
            rcnt = 2'd2;
            if (in0 && in1) begin
              ang = (q0 < q1) ? q0[AW-1:0] : q1[AW-1:0];
              cl  = 1'b0;
            end else if (in0) begin
              ang = q0[AW-1:0];
              cl  = 1'b0;
            end else if (in1) begin
              ang = q1[AW-1:0];
              cl  = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, refilled while the last word is taken
  assign load  = (state == B_DONE) && (!out_v || pop);
  assign empty = !out_v;
  assign ang_x = {1'b0, ang};

  always_ff @(posedge clk) begin
    if (load) begin
      result.fin_angle  <= fpos ? ang_x : (~ang_x + 24'd1);
      result.root_count <= rcnt;
      result.clamped    <= cl || jclamp;
    end
  end

  `FAF_IMPLY(a_lin_one_div, (state == B_DIV) && (kind == faf_pkg::KIND_LIN), !busy1, "second divider busy on linear curve")
  `FAF_IMPLY(a_angle_limit, load, ang <= lim, "angle beyond limit")
  `FAF_IMPLY(a_noroot_clamps, load && (rcnt == 2'd0), cl, "no root without clamp")
  `FAF_NEXT(a_pop_leaves_idle, q_pop, state != B_IDLE, "queue word taken but solver idle")

endmodule

// File: hdl/fin_angle_from_force_top.sv
// The front end can take a new word while its coefficient divider still works on
//   the last; the back end solves one word at a time, through a 41-step square
//   root and a 24-step root division on a quadratic curve.
// Reset (rst, synchronous): clears the queue and the stage valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
// fin_angle_from_force_top
// Converts a demanded fin force and propeller speed into a limited fin angle.
// ----------------------------------------------------------------------------
module fin_angle_from_force_top #(
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  faf_pkg::item_t                    item,
  output logic                              empty,
  input  logic                              pop,
  output faf_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [faf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);

  faf_pkg::cfg_t cfg;
  faf_pkg::job_t f_job;
  faf_pkg::job_t b_job;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lift_coeff_a  <= 32'sd0;
      cfg.lift_coeff_b  <= 32'sd65536;
      cfg.lift_coeff_c  <= 32'sd0;
      cfg.max_angle     <= 23'd1310720;
      cfg.prop_constant <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        faf_pkg::REG_LIFT_A:     cfg.lift_coeff_a  <= cfg_data;
        faf_pkg::REG_LIFT_B:     cfg.lift_coeff_b  <= cfg_data;
        faf_pkg::REG_LIFT_C:     cfg.lift_coeff_c  <= cfg_data;
        faf_pkg::REG_MAX_ANGLE:  cfg.max_angle     <= cfg_data[22:0];
        faf_pkg::REG_PROP_CONST: cfg.prop_constant <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  faf_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .job    (f_job)
  );

  faf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (b_job),
    .empty (q_empty)
  );

  faf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .job     (b_job),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
